FILE: src/clt_pkg.sv
// Package: types and constants shared by the counted lock table.
`timescale 1ns / 1ps
package clt_pkg;

  localparam int DefBuckets     = 64;
  localparam int DefPoolEntries = 256;
  localparam int DefNumPools    = 2;

  localparam logic [15:0] MaxCount = 16'hFFFF;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_LOCK   = 2'd1,
    ST_FULL      = 2'd2,
    ST_COUNT_MAX = 2'd3
  } status_t;

  typedef struct packed {
    logic        kind;
    logic        pool_sel;
    logic [15:0] vol_no;
    logic [31:0] page_no;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] holders;
    logic        created;
    logic        freed;
  } rsp_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_HEAD,
    S_HEAD_WAIT,
    S_READ,
    S_CHECK,
    S_UNLINK,
    S_FREE_SCAN,
    S_FREE_WAIT,
    S_ALLOC,
    S_RESULT
  } fsm_t;

endpackage

FILE: src/counted_lock_table_core.sv
// Top level: reference-counted lock table with chained hash buckets in RAM.
// A request reads its bucket head, then checks chain entries one by one; a lock miss
// scans the pool for a free entry and allocates it, and a free of the last holder adds an unlink write.
// One word at a time; the next word is taken in the cycle after the result is taken.
// Reset (rst, synchronous, active high) starts a clearing pass over max(entries, buckets)
// addresses with in_stall high; it zeroes valid and bucket-used bits.
`timescale 1ns / 1ps
module counted_lock_table_core
  import clt_pkg::*;
#(
  parameter int BUCKETS      = DefBuckets,
  parameter int POOL_ENTRIES = DefPoolEntries,
  parameter int NUM_POOLS    = DefNumPools
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  localparam int EW = (POOL_ENTRIES > 1) ? $clog2(POOL_ENTRIES) : 1;
  localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
  localparam int PW = (NUM_POOLS > 1) ? $clog2(NUM_POOLS) : 1;
  localparam int NE = NUM_POOLS * POOL_ENTRIES;
  localparam int NB = NUM_POOLS * BUCKETS;
  localparam int EAW = (NE > 1) ? $clog2(NE) : 1;
  localparam int BAW = (NB > 1) ? $clog2(NB) : 1;
  localparam int SW = EW + 1;
  localparam int CN = (NE > NB) ? NE : NB;
  localparam int CW = (CN > 1) ? $clog2(CN) : 1;

  // entry RAM: valid, key, count, link packed in one word
  typedef struct packed {
    logic          vld;
    logic [47:0]   key;
    logic [15:0]   count;
    logic [EW-1:0] nxt;
  } ent_t;

  // bucket RAM: chain-not-empty flag and head index
  typedef struct packed {
    logic          used;
    logic [EW-1:0] head;
  } hd_t;

  ent_t           ent_mem [NE];
  hd_t            head_mem [NB];

  fsm_t state, state_next;

  req_t           req;
  logic [PW-1:0]  pool;
  logic [BW-1:0]  bkt;
  logic [EW-1:0]  cur, prev, free_idx;
  logic           has_prev;
  logic [SW-1:0]  steps;
  ent_t           ent_rd;
  hd_t            head_rd;
  logic           found;
  rsp_t           rsp;
  logic [CW-1:0]  clr_idx;

  // memory port controls
  logic           ent_we;
  logic [EAW-1:0] ent_waddr, ent_raddr;
  ent_t           ent_wdata;
  logic           head_we;
  logic [BAW-1:0] head_waddr;
  hd_t            head_wdata;

  // exact 33-bit sum, reduced modulo BUCKETS
  logic [32:0] ksum;
  logic [BW-1:0] in_bkt;
  assign ksum   = {17'd0, in_data.vol_no} + {1'b0, in_data.page_no};
  assign in_bkt = BW'(ksum % 33'(BUCKETS));

  function automatic logic [EAW-1:0] eaddr(input logic [PW-1:0] p, input logic [EW-1:0] i);
    eaddr = EAW'(EAW'(p) * EAW'(POOL_ENTRIES) + EAW'(i));
  endfunction

  logic [BAW-1:0] baddr;
  assign baddr = BAW'(BAW'(pool) * BAW'(BUCKETS) + BAW'(bkt));

  logic [47:0] key;
  assign key = {req.vol_no, req.page_no};

  always_ff @(posedge clk) begin
    if (ent_we) ent_mem[ent_waddr] <= ent_wdata;
    ent_rd <= ent_mem[ent_raddr];
    if (head_we) head_mem[head_waddr] <= head_wdata;
    head_rd <= head_mem[baddr];
  end

  assign in_stall  = (state != S_IDLE);
  assign out_valid = (state == S_RESULT);
  assign out_data  = rsp;

  logic last, cnt_max, cnt_one, steps_done, free_hit, clr_done;
  assign last       = (ent_rd.nxt == cur);
  assign cnt_max    = (ent_rd.count == MaxCount);
  assign cnt_one    = (ent_rd.count <= 16'd1);
  assign steps_done = (steps == SW'(POOL_ENTRIES - 1));
  assign free_hit   = !ent_rd.vld;
  assign clr_done   = (clr_idx == CW'(CN - 1));

  always_comb begin
    found = ent_rd.vld && (ent_rd.key == key);
  end

  // last holder leaves: relink around the entry, then clear it
  logic unlink;
  assign unlink = (state == S_CHECK) && found && req.kind && cnt_one;

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:     if (clr_done) state_next = S_IDLE;
      S_IDLE:      if (in_valid) state_next = S_HEAD;
      S_HEAD:      state_next = S_HEAD_WAIT;
      S_HEAD_WAIT: state_next = head_rd.used ? S_READ : (req.kind ? S_RESULT : S_FREE_SCAN);
      S_READ:      state_next = S_CHECK;
      S_CHECK: begin
        if (found || last || steps_done) begin
          if (!found && !req.kind) state_next = S_FREE_SCAN;
          else if (unlink) state_next = S_UNLINK;
          else state_next = S_RESULT;
        end else begin
          state_next = S_READ;
        end
      end
      S_UNLINK:    state_next = S_RESULT;
      S_FREE_SCAN: state_next = S_FREE_WAIT;
      S_FREE_WAIT: begin
        if (free_hit) state_next = S_ALLOC;
        else if (free_idx == EW'(POOL_ENTRIES - 1)) state_next = S_RESULT;
        else state_next = S_FREE_SCAN;
      end
      S_ALLOC:     state_next = S_RESULT;
      S_RESULT:    if (!out_stall) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  ent_t prev_ent;
  always_ff @(posedge clk) begin
    if (state == S_CHECK && !found) prev_ent <= ent_rd;
  end

  // memory writes and read addresses
  always_comb begin
    ent_we     = 1'b0;
    ent_waddr  = eaddr(pool, cur);
    ent_wdata  = ent_rd;
    head_we    = 1'b0;
    head_waddr = baddr;
    head_wdata = head_rd;
    ent_raddr  = eaddr(pool, cur);
    unique case (state)
      S_CLEAR: begin
        ent_we     = (32'(clr_idx) < NE);
        ent_waddr  = EAW'(clr_idx);
        ent_wdata  = '0;
        head_we    = (32'(clr_idx) < NB);
        head_waddr = BAW'(clr_idx);
        head_wdata = '0;
      end
      S_CHECK: begin
        if (found && !req.kind && !cnt_max) begin
          ent_we = 1'b1;
          ent_wdata.count = ent_rd.count + 16'd1;
        end else if (found && req.kind && !cnt_one) begin
          ent_we = 1'b1;
          ent_wdata.count = ent_rd.count - 16'd1;
        end else if (unlink && has_prev) begin
          ent_we    = 1'b1;
          ent_waddr = eaddr(pool, prev);
          ent_wdata = prev_ent;
          ent_wdata.nxt = last ? prev : ent_rd.nxt;
        end else if (unlink) begin
          head_we = 1'b1;
          head_wdata.used = !last;
          head_wdata.head = ent_rd.nxt;
        end
      end
      S_UNLINK: begin
        ent_we    = 1'b1;
        ent_wdata = '0;
      end
      S_FREE_SCAN: ent_raddr = eaddr(pool, free_idx);
      S_ALLOC: begin
        ent_we    = 1'b1;
        ent_waddr = eaddr(pool, free_idx);
        ent_wdata.vld   = 1'b1;
        ent_wdata.key   = key;
        ent_wdata.count = 16'd1;
        ent_wdata.nxt   = head_rd.used ? head_rd.head : free_idx;
        head_we = 1'b1;
        head_wdata.used = 1'b1;
        head_wdata.head = free_idx;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_CLEAR;
      clr_idx <= '0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) clr_idx <= clr_idx + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        req  <= in_data;
        pool <= PW'(32'(in_data.pool_sel) % NUM_POOLS);
        bkt  <= in_bkt;
      end
      S_HEAD_WAIT: begin
        cur      <= head_rd.head;
        has_prev <= 1'b0;
        steps    <= '0;
        free_idx <= '0;
        rsp      <= req.kind ? rsp_t'{ST_NO_LOCK, 16'd0, 1'b0, 1'b0}
                             : rsp_t'{ST_FULL, 16'd0, 1'b0, 1'b0};
      end
      S_CHECK: begin
        if (found) begin
          if (!req.kind)
            rsp <= cnt_max ? rsp_t'{ST_COUNT_MAX, MaxCount, 1'b0, 1'b0}
                           : rsp_t'{ST_OK, ent_rd.count + 16'd1, 1'b0, 1'b0};
          else
            rsp <= cnt_one ? rsp_t'{ST_OK, 16'd0, 1'b0, 1'b1}
                           : rsp_t'{ST_OK, ent_rd.count - 16'd1, 1'b0, 1'b0};
        end else if (!last && !steps_done) begin
          prev     <= cur;
          has_prev <= 1'b1;
          cur      <= ent_rd.nxt;
          steps    <= steps + SW'(1);
        end
      end
      S_FREE_WAIT: if (!free_hit) free_idx <= free_idx + EW'(1);
      S_ALLOC: rsp <= rsp_t'{ST_OK, 16'd1, 1'b1, 1'b0};
      default: ;
    endcase
  end

endmodule
